[rtl/pta_pkg.sv]
// Shared constants, types and item codes for the palette tile atlas packer.
package pta_pkg;

    localparam int ATLAS_SIZE     = 1024;
    localparam int FRAG_DIM       = 64;
    localparam int BORDER         = 2;
    localparam int PALETTE_DEPTH  = 256;

    localparam int CELL_SIZE      = FRAG_DIM + 2 * BORDER;
    localparam int CELLS_PER_LINE = ATLAS_SIZE / CELL_SIZE;

    localparam int COORD_W = $clog2(ATLAS_SIZE);
    localparam int SRC_W   = $clog2(FRAG_DIM);
    localparam int CELL_W  = (CELLS_PER_LINE > 1) ? $clog2(CELLS_PER_LINE) : 1;
    localparam int PAL_W   = $clog2(PALETTE_DEPTH);
    localparam int TILE_W  = 9;
    localparam int COLOR_W = 32;
    localparam int CNT_W   = $clog2(BORDER + 2);
    localparam int MODE_W  = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_PIXEL   = 2'd1,
        MODE_RESTART = 2'd2
    } t_mode;

    // One placed pixel: a block of nx by ny atlas positions filled with one colour.
    typedef struct packed {
        logic [TILE_W-1:0]  tile;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [CNT_W-1:0]   nx;
        logic [CNT_W-1:0]   ny;
        logic [COLOR_W-1:0] color;
    } t_job;

endpackage

[rtl/palette_tile_atlas_packer.sv]
// Top level of the palette tile atlas packer.
//
// Input channel (i_valid / o_stall): one item per accepted edge. Mode 0 loads
// a palette colour (stored at the index with bits 3 and 4 swapped, red/blue
// exchanged, alpha saturated-doubled), mode 1 places one fragment pixel,
// mode 2 restarts the tile/cell/source counters. Mode 3 is ignored.
// Output channel (o_valid / i_stall): one placed atlas pixel per item.
// A fragment pixel gives 1 result inside the fragment, 3 on an edge and
// 9 on a corner (border replication); o_last flags the final one.
// Throughput: the front end takes one item per cycle while o_stall is low;
// the emitter sends one result per cycle while i_stall is low. A 4-entry
// job queue absorbs corner bursts. An accepted pixel passes the job stage
// register, the job queue and the output register before its first result.
// Reset clears the counters, queue and output valid, and o_stall stays high
// while reset is held; the palette keeps its contents. A palette entry is to
// be written before it is read; the block itself does not enforce this.
// While i_stall is high the output register holds; the queue fills, then
// o_stall rises and the input side waits. Loads and restarts never wait
// on the output side unless the job stage is blocked.
module palette_tile_atlas_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pta_pkg::MODE_W-1:0]    i_mode,
    input  logic [7:0]                    i_pal_index,
    input  logic [pta_pkg::COLOR_W-1:0]   i_pal_word,
    input  logic [7:0]                    i_pixel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pta_pkg::TILE_W-1:0]    o_tile,
    output logic [pta_pkg::COORD_W-1:0]   o_pos_x,
    output logic [pta_pkg::COORD_W-1:0]   o_pos_y,
    output logic [pta_pkg::COLOR_W-1:0]   o_color,
    output logic                          o_last
);
    import pta_pkg::*;

    logic push, full, job_valid, pop;
    t_job push_job, head_job;

    pta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_pal_index (i_pal_index),
        .i_pal_word  (i_pal_word),
        .i_pixel     (i_pixel),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    pta_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .o_valid (job_valid),
        .o_data  (head_job),
        .i_pop   (pop)
    );

    pta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tile      (o_tile),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_color     (o_color),
        .o_last      (o_last)
    );

    // Queue never written while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("job queue overflow");

    // Queue never popped while empty.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> job_valid)
        else $error("job queue underflow");

    // A taken non-final result is followed directly by the next one of the same job.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("result burst broken");

endmodule

[rtl/pta_front.sv]
// Front end: item intake, palette store, fragment counters and job build.
module pta_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pta_pkg::MODE_W-1:0]    i_mode,
    input  logic [7:0]                    i_pal_index,
    input  logic [pta_pkg::COLOR_W-1:0]   i_pal_word,
    input  logic [7:0]                    i_pixel,
    output logic                          o_push,
    output pta_pkg::t_job                 o_job,
    input  logic                          i_full
);
    import pta_pkg::*;

    function automatic logic [7:0] swizzle(input logic [7:0] idx);
        logic [7:0] res;
        res    = idx;
        res[3] = idx[4];
        res[4] = idx[3];
        return res;
    endfunction

    function automatic logic [COLOR_W-1:0] convert(input logic [COLOR_W-1:0] w);
        logic [7:0] alpha;
        alpha = w[31] ? 8'hFF : {w[30:24], 1'b0};
        return {alpha, w[7:0], w[15:8], w[23:16]};
    endfunction

    logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] r_rd_data;
    logic [7:0]         wr_slot;

    logic [TILE_W-1:0]  r_tile;
    logic [CELL_W-1:0]  r_cell_row, r_cell_col;
    logic [SRC_W-1:0]   r_src_row, r_src_col;

    logic               r_s1_valid;
    logic [TILE_W-1:0]  r_s1_tile;
    logic [COORD_W-1:0] r_s1_x0, r_s1_y0;
    logic [CNT_W-1:0]   r_s1_nx, r_s1_ny;

    logic               accept, do_load, do_pixel, do_restart;
    logic               col_end, row_end, ccol_end, crow_end;
    logic [COORD_W-1:0] cell_x, cell_y, n_x0, n_y0;
    logic [CNT_W-1:0]   n_nx, n_ny;

    // no intake while reset is held
    assign o_stall = !i_rst_n || (r_s1_valid && i_full);
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_s1_valid && !i_full;
    assign wr_slot = swizzle(i_pal_index);

    always_comb begin
        do_load    = 1'b0;
        do_pixel   = 1'b0;
        do_restart = 1'b0;
        unique case (t_mode'(i_mode))
            MODE_LOAD:    do_load    = accept;
            MODE_PIXEL:   do_pixel   = accept;
            MODE_RESTART: do_restart = accept;
            default: ;
        endcase
    end

    assign col_end  = (r_src_col == SRC_W'(FRAG_DIM - 1));
    assign row_end  = (r_src_row == SRC_W'(FRAG_DIM - 1));
    assign ccol_end = (r_cell_col == CELL_W'(CELLS_PER_LINE - 1));
    assign crow_end = (r_cell_row == CELL_W'(CELLS_PER_LINE - 1));

    // Cell origin; a first-row/col pixel starts BORDER early (covers the margin).
    always_comb begin
        cell_x = COORD_W'(COORD_W'(r_cell_col) * COORD_W'(CELL_SIZE));
        cell_y = COORD_W'(COORD_W'(r_cell_row) * COORD_W'(CELL_SIZE));
        n_x0 = (r_src_col == '0) ? cell_x
                                 : COORD_W'(cell_x + COORD_W'(BORDER) + COORD_W'(r_src_col));
        n_y0 = (r_src_row == '0) ? cell_y
                                 : COORD_W'(cell_y + COORD_W'(BORDER) + COORD_W'(r_src_row));
        n_nx = ((r_src_col == '0) || col_end) ? CNT_W'(BORDER + 1) : CNT_W'(1);
        n_ny = ((r_src_row == '0) || row_end) ? CNT_W'(BORDER + 1) : CNT_W'(1);
    end

    // Palette store: written on load, read on pixel; read data registered.
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            mem[wr_slot[PAL_W-1:0]] <= convert(i_pal_word);
        end
        if (do_pixel) begin
            r_rd_data <= mem[i_pixel[PAL_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pixel) begin
            r_s1_tile <= r_tile;
            r_s1_x0   <= n_x0;
            r_s1_y0   <= n_y0;
            r_s1_nx   <= n_nx;
            r_s1_ny   <= n_ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (do_pixel) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_restart) begin
            r_tile     <= '0;
            r_cell_row <= '0;
            r_cell_col <= '0;
            r_src_row  <= '0;
            r_src_col  <= '0;
        end else if (do_pixel) begin
            r_src_col <= col_end ? '0 : SRC_W'(r_src_col + 1'b1);
            if (col_end) begin
                r_src_row <= row_end ? '0 : SRC_W'(r_src_row + 1'b1);
                if (row_end) begin
                    r_cell_col <= ccol_end ? '0 : CELL_W'(r_cell_col + 1'b1);
                    if (ccol_end) begin
                        r_cell_row <= crow_end ? '0 : CELL_W'(r_cell_row + 1'b1);
                        if (crow_end) begin
                            r_tile <= TILE_W'(r_tile + 1'b1);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        o_job.tile  = r_s1_tile;
        o_job.x0    = r_s1_x0;
        o_job.y0    = r_s1_y0;
        o_job.nx    = r_s1_nx;
        o_job.ny    = r_s1_ny;
        o_job.color = r_rd_data;
    end

endmodule

[rtl/pta_fifo.sv]
// Short job queue between front end and emitter.
module pta_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pta_pkg::t_job i_data,
    output logic          o_full,
    output logic          o_valid,
    output pta_pkg::t_job o_data,
    input  logic          i_pop
);
    import pta_pkg::*;

    t_job              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QPTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QPTR_W'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= (QPTR_W + 1)'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= (QPTR_W + 1)'(r_cnt - 1'b1);
            end
        end
    end

endmodule

[rtl/pta_back.sv]
// Emitter: walks each job's block of positions, one result per cycle while i_stall is low.
module pta_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  pta_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pta_pkg::TILE_W-1:0]    o_tile,
    output logic [pta_pkg::COORD_W-1:0]   o_pos_x,
    output logic [pta_pkg::COORD_W-1:0]   o_pos_y,
    output logic [pta_pkg::COLOR_W-1:0]   o_color,
    output logic                          o_last
);
    import pta_pkg::*;

    logic [CNT_W-1:0] r_i, r_j;
    logic             adv, x_end, y_end, emit;

    assign adv   = !o_valid || !i_stall;
    assign emit  = adv && i_job_valid;
    assign x_end = (r_j == CNT_W'(i_job.nx - 1'b1));
    assign y_end = (r_i == CNT_W'(i_job.ny - 1'b1));
    assign o_pop = emit && x_end && y_end;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_tile  <= i_job.tile;
            o_pos_x <= COORD_W'(i_job.x0 + COORD_W'(r_j));
            o_pos_y <= COORD_W'(i_job.y0 + COORD_W'(r_i));
            o_color <= i_job.color;
            o_last  <= x_end && y_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else if (adv) begin
            o_valid <= i_job_valid;
            if (i_job_valid) begin
                if (x_end) begin
                    r_j <= '0;
                    r_i <= y_end ? '0 : CNT_W'(r_i + 1'b1);
                end else begin
                    r_j <= CNT_W'(r_j + 1'b1);
                end
            end
        end
    end

endmodule
